// ===== sv/gdm_pkg.sv =====
// gauge duty map package: table geometry, reciprocal constants, codes and shared types
// no dependencies; used by every other file of the block
`default_nettype none

package gdm_pkg;

	// virtual table and calibration geometry
	localparam int TABLE_SIZE  = 101;
	localparam int NPOINTS     = 5;
	localparam int DW          = 15;
	localparam int ONE_PERCENT = 256;
	localparam int FULL_SCALE  = 25600;
	localparam int SNAP_GAP    = 2 * ONE_PERCENT;
	localparam int RD_RAW      = (TABLE_SIZE - 1) / 4;
	localparam int RD          = (RD_RAW < 1) ? 1 : RD_RAW;
	localparam int IW          = $clog2(TABLE_SIZE);
	localparam int KW          = $clog2(RD + 1);
	localparam int CFG_IW      = 3;

	// index: floor((2*gp*TABLE_SIZE + 25600) / 51200) = floor((num >> 10) / 50)
	localparam int NUM_MAX   = 32767 * 2 * TABLE_SIZE + FULL_SCALE;
	localparam int NUMW      = $clog2(32768 * 2 * TABLE_SIZE + FULL_SCALE + 1) + 1;
	localparam int IDX_SHIFT = 10;
	localparam int DIV1      = 51200 / (1 << IDX_SHIFT);
	localparam int N1W       = $clog2((NUM_MAX >> IDX_SHIFT) + 1);
	localparam int S1        = N1W + $clog2(DIV1);
	localparam longint unsigned M1 = ((64'd1 << S1) + 64'(DIV1) - 64'd1) / 64'(DIV1);
	localparam int M1W       = $clog2(M1 + 1);
	localparam int Q1W       = N1W + M1W - S1;

	// interpolation rounding: (2*mag + RD) / (2*RD)
	localparam int PW     = KW + DW + 2;
	localparam int MAGW   = KW + DW;
	localparam int N2_MAX = 2 * (RD - 1) * 32767 + RD;
	localparam int N2W    = $clog2(N2_MAX + 1);
	localparam int D2     = 2 * RD;
	localparam int S2     = N2W + $clog2(D2);
	localparam longint unsigned M2 = ((64'd1 << S2) + 64'(D2) - 64'd1) / 64'(D2);
	localparam int M2W    = $clog2(M2 + 1);
	localparam int Q2W    = N2W + M2W - S2;

	localparam logic [NPOINTS-1:0][DW-1:0] CAL_RESET = {
		15'd25600, 15'd19200, 15'd12800, 15'd6400, 15'd0
	};

	typedef enum logic [1:0] {
		MODE_SET    = 2'd0,
		MODE_TARGET = 2'd1,
		MODE_TICK   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_CAL0     = 3'd0,
		CFG_CAL1     = 3'd1,
		CFG_CAL2     = 3'd2,
		CFG_CAL3     = 3'd3,
		CFG_CAL4     = 3'd4,
		CFG_DRIVE_EN = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [NPOINTS-1:0][DW-1:0] cal_pt;
		logic                       drive_enable;
		logic                       cal_valid;
	} cfg_t;

	typedef struct packed {
		logic          valid;
		mode_t         mode;
		logic [DW-1:0] duty;
	} map_out_t;

	typedef struct packed {
		logic [DW-1:0] cur;
		logic [DW-1:0] tgt;
	} duty_state_t;

endpackage

`default_nettype wire

// ===== sv/gdm_if.sv =====
// request, result and register-write channel interfaces of the gauge duty map
// depends on gdm_pkg for field widths
`default_nettype none

interface gdm_in_if import gdm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic signed [15:0] gauge_percent;

	modport source (output valid, output mode, output gauge_percent, input ready);
	modport sink (input valid, input mode, input gauge_percent, output ready);
endinterface

interface gdm_out_if import gdm_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [DW-1:0] duty;
	logic          at_target;
	logic          cal_valid;
	logic          enable_pin;
	logic          enable_pin_n;

	modport source (output valid, output duty, output at_target, output cal_valid,
		output enable_pin, output enable_pin_n, input ready);
	modport sink (input valid, input duty, input at_target, input cal_valid,
		input enable_pin, input enable_pin_n, output ready);
endinterface

interface gdm_cfg_if import gdm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [DW-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/gauge_duty_map_with_ramp.sv =====
// gauge duty map with ramp: top level
// depends on gdm_pkg, gdm_if, gdm_cfg_regs, gdm_map and gdm_ramp
//
// usage
//   item: request with mode and a signed gauge reading in 1/256 percent units.
//     mode set writes the mapped duty to both current and target, mode target
//     loads only the ramp target, mode tick moves the duty one percent toward
//     the target or snaps onto it, the unused mode just reports.
//   result: one result per request with duty, at_target, cal_valid and the
//     two driver enable levels.
//   cfg: register writes (five calibration points, then drive enable); always
//     ready, write only while no request is in flight.
// timing
//   one request per cycle sustained while results are taken; a request passes
//   five mapping stages (index scaling, divide by reciprocal, segment multiply,
//   rounding reciprocal, final add) and the state read-modify-write stage that
//   loads the result register.
//   the duty state sits in a one-entry memory with a registered read; the
//   write of the previous request is forwarded so back-to-back ticks chain.
// reset: calibration points return to a straight 0..100 percent line, driver
//   disabled, duty and target zero, pipe empty.
// stall: when the result is not taken the whole pipe holds and item ready drops;
//   the result register frees up the same cycle it is taken.
`default_nettype none

module gauge_duty_map_with_ramp import gdm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gdm_in_if.sink    item,
	gdm_out_if.source result,
	gdm_cfg_if.sink   cfg
);

	cfg_t     cfg_s;
	map_out_t mapped;
	logic     adv;

	// request side stalls with the whole pipe
	assign item.ready = adv;

	gdm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_s)
	);

	// reading to interpolated duty
	gdm_map u_map (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.item_valid    (item.valid),
		.item_mode     (mode_t'(item.mode)),
		.gauge_percent (item.gauge_percent),
		.cfg           (cfg_s),
		.mapped        (mapped)
	);

	// state update and result register
	gdm_ramp u_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.mapped (mapped),
		.cfg    (cfg_s),
		.adv    (adv),
		.result (result)
	);

`ifndef SYNTHESIS
	// an immediate set lands on its own target
	a_set_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		mapped.valid && adv && (mapped.mode == MODE_SET)
		|=> result.valid && result.at_target && (result.duty == $past(mapped.duty)))
		else $error("set request did not land at target");

	// a stalled pipe keeps the mapped item
	a_map_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mapped.valid && !adv
		|=> mapped.valid && $stable(mapped.duty) && $stable(mapped.mode))
		else $error("mapped item changed while stalled");

	// valid calibration never has equal first points
	a_cal_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_s.cal_valid |-> ($past(cfg_s.cal_pt[0]) != $past(cfg_s.cal_pt[1])))
		else $error("calibration flagged valid with equal first points");
`endif

endmodule

`default_nettype wire

// ===== sv/gdm_cfg_regs.sv =====
// calibration and drive-enable registers with a registered calibration check
// depends on gdm_pkg and gdm_cfg_if
`default_nettype none

module gdm_cfg_regs import gdm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	gdm_cfg_if.sink      cfg,
	output cfg_t         regs
);

	logic [NPOINTS-1:0][DW-1:0] cal_pt_q;
	logic                       drive_en_q;
	logic                       cal_valid_q;
	logic                       cal_ok;
	logic                       inc;

	assign cfg.ready = 1'b1;

	// points in 0..100 percent and strictly monotonic
	always_comb begin
		inc    = cal_pt_q[1] > cal_pt_q[0];
		cal_ok = 1'b1;
		for (int i = 0; i < NPOINTS; i++) begin
			if (cal_pt_q[i] > DW'(FULL_SCALE)) begin
				cal_ok = 1'b0;
			end
		end
		for (int i = 0; i < NPOINTS - 1; i++) begin
			if (inc ? (cal_pt_q[i+1] <= cal_pt_q[i]) : (cal_pt_q[i+1] >= cal_pt_q[i])) begin
				cal_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_pt_q    <= CAL_RESET;
			drive_en_q  <= 1'b0;
			cal_valid_q <= 1'b1; // reset points are a valid rising set
		end else begin
			cal_valid_q <= cal_ok;
			if (cfg.valid) begin
				case (cfg.index)
					CFG_CAL0, CFG_CAL1, CFG_CAL2, CFG_CAL3, CFG_CAL4: begin
						cal_pt_q[cfg.index] <= cfg.data;
					end
					CFG_DRIVE_EN: begin
						drive_en_q <= cfg.data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign regs.cal_pt       = cal_pt_q;
	assign regs.drive_enable = drive_en_q;
	assign regs.cal_valid    = cal_valid_q;

endmodule

`default_nettype wire

// ===== sv/gdm_map.sv =====
// five-stage mapping pipe: gauge reading to table index to interpolated duty
// depends on gdm_pkg; calibration points come from gdm_cfg_regs
`default_nettype none

module gdm_map import gdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              item_valid,
	input  mode_t             item_mode,
	input  logic signed [15:0] gauge_percent,
	input  cfg_t              cfg,
	output map_out_t          mapped
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	mode_t mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6;

	logic signed [15:0]     gp_s1;
	logic signed [NUMW-1:0] num;
	logic [N1W-1:0]         n1;
	logic [N1W-1:0]         n1_s2;
	logic [N1W+M1W-1:0]     prod1;
	logic [N1W+M1W-1:0]     prod1_s3;
	logic [Q1W-1:0]         q1;
	logic [IW-1:0]          idx;
	logic [IW-1:0]          base;
	logic [1:0]             seg;
	logic                   tail;
	logic [KW-1:0]          k;
	logic [DW-1:0]          lo;
	logic [DW-1:0]          hi;
	logic signed [DW:0]     diff;
	logic signed [PW-1:0]   prod2;
	logic signed [PW-1:0]   prod2_s4;
	logic [DW-1:0]          lo_s4;
	logic                   neg;
	logic [MAGW-1:0]        mag;
	logic [N2W-1:0]         n2;
	logic [N2W+M2W-1:0]     prod3;
	logic [N2W+M2W-1:0]     prod3_s5;
	logic                   neg_s5;
	logic [DW-1:0]          lo_s5;
	logic [Q2W-1:0]         q2;
	logic [DW-1:0]          duty;
	logic [DW-1:0]          duty_s6;

	// s1: scale the reading, drop negatives, pre-shift by 1024
	assign num = NUMW'(gp_s1) * NUMW'(2 * TABLE_SIZE) + NUMW'(FULL_SCALE);
	assign n1  = num[NUMW-1] ? '0 : num[IDX_SHIFT +: N1W];

	// s2: divide by 50 through the reciprocal
	assign prod1 = n1_s2 * M1W'(M1);

	// s3: clamp index, pick segment and offset, multiply offset by slope
	assign q1  = prod1_s3[S1 +: Q1W];
	assign idx = (q1 > Q1W'(TABLE_SIZE - 1)) ? IW'(TABLE_SIZE - 1) : IW'(q1);

	always_comb begin
		tail = 1'b0;
		seg  = 2'd0;
		base = '0;
		if (idx >= IW'(4 * RD)) begin
			tail = 1'b1;
		end else if (idx >= IW'(3 * RD)) begin
			seg  = 2'd3;
			base = IW'(3 * RD);
		end else if (idx >= IW'(2 * RD)) begin
			seg  = 2'd2;
			base = IW'(2 * RD);
		end else if (idx >= IW'(RD)) begin
			seg  = 2'd1;
			base = IW'(RD);
		end
	end

	// table tail reads the last point with a zero offset
	assign k     = tail ? '0 : KW'(idx - base);
	assign lo    = tail ? cfg.cal_pt[NPOINTS-1] : cfg.cal_pt[3'(seg)];
	assign hi    = cfg.cal_pt[3'(seg) + 3'd1];
	assign diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
	assign prod2 = $signed({1'b0, k}) * diff;

	// s4: rounding numerator times reciprocal of 2*RD
	assign neg   = prod2_s4[PW-1];
	assign mag   = MAGW'(neg ? -prod2_s4 : prod2_s4);
	assign n2    = N2W'({mag, 1'b0}) + N2W'(RD);
	assign prod3 = n2 * M2W'(M2);

	// s5: apply signed rounded step
	assign q2   = prod3_s5[S2 +: Q2W];
	assign duty = neg_s5 ? (lo_s5 - DW'(q2)) : (lo_s5 + DW'(q2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1  <= item_mode;
			gp_s1    <= gauge_percent;
			mode_s2  <= mode_s1;
			n1_s2    <= n1;
			mode_s3  <= mode_s2;
			prod1_s3 <= prod1;
			mode_s4  <= mode_s3;
			prod2_s4 <= prod2;
			lo_s4    <= lo;
			mode_s5  <= mode_s4;
			prod3_s5 <= prod3;
			neg_s5   <= neg;
			lo_s5    <= lo_s4;
			mode_s6  <= mode_s5;
			duty_s6  <= duty;
		end
	end

	assign mapped.valid = v_s6;
	assign mapped.mode  = mode_s6;
	assign mapped.duty  = duty_s6;

endmodule

`default_nettype wire

// ===== sv/gdm_ramp.sv =====
// duty state memory with read-modify-write, slew limiting and the result register
// depends on gdm_pkg and gdm_out_if
`default_nettype none

module gdm_ramp import gdm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  map_out_t  mapped,
	input  cfg_t      cfg,
	output logic      adv,
	gdm_out_if.source result
);

	duty_state_t state_mem [0:0];
	logic        mem_valid_q;
	duty_state_t rd_q;
	duty_state_t fwd_q;
	logic        fwd_valid_q;
	duty_state_t view;
	duty_state_t nxt;
	logic [DW-1:0] gap;
	logic        commit;

	logic          res_valid_q;
	logic [DW-1:0] res_duty_q;
	logic          res_at_tgt_q;
	logic          res_cal_valid_q;
	logic          res_en_q;

	assign adv    = !res_valid_q || result.ready;
	assign commit = mapped.valid && adv;

	// last write bypasses the memory read of the same edge
	assign view = fwd_valid_q ? fwd_q : rd_q;
	assign gap  = (view.cur > view.tgt) ? (view.cur - view.tgt) : (view.tgt - view.cur);

	always_comb begin
		nxt = view;
		case (mapped.mode)
			MODE_SET: begin
				nxt.cur = mapped.duty;
				nxt.tgt = mapped.duty;
			end
			MODE_TARGET: begin
				nxt.tgt = mapped.duty;
			end
			MODE_TICK: begin
				// within two percent the one-percent step lands near enough to snap
				if (gap <= DW'(SNAP_GAP)) begin
					nxt.cur = view.tgt;
				end else if (view.cur > view.tgt) begin
					nxt.cur = view.cur - DW'(ONE_PERCENT);
				end else begin
					nxt.cur = view.cur + DW'(ONE_PERCENT);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			state_mem[0] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_valid_q <= 1'b0;
			rd_q        <= '0;
			fwd_valid_q <= 1'b0;
			fwd_q       <= '0;
		end else begin
			rd_q        <= mem_valid_q ? state_mem[0] : '0;
			fwd_valid_q <= commit;
			if (commit) begin
				mem_valid_q <= 1'b1;
				fwd_q       <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= mapped.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_duty_q      <= nxt.cur;
			res_at_tgt_q    <= (nxt.cur == nxt.tgt);
			res_cal_valid_q <= cfg.cal_valid;
			res_en_q        <= cfg.drive_enable;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.duty         = res_duty_q;
	assign result.at_target    = res_at_tgt_q;
	assign result.cal_valid    = res_cal_valid_q;
	assign result.enable_pin   = res_en_q;
	assign result.enable_pin_n = !res_en_q;

endmodule

`default_nettype wire

// ===== dv/gauge_duty_map_with_ramp_test.sv =====
// testbench for gauge_duty_map_with_ramp: directed and random requests through the
// request, result and register-write channels, checked against an in-bench predictor
// depends on gdm_pkg, the gdm interfaces and the block itself
`timescale 1ns / 1ps

module gauge_duty_map_with_ramp_test;
	import gdm_pkg::*;

	// mapping divisor: index = floor((2*gp*TABLE_SIZE + FULL_SCALE) / IDX_DEN)
	localparam int IDX_DEN = 2 * FULL_SCALE;
	// cycles let pass after the last result before a register write or the end
	localparam int SETTLE = 12;
	// long receiver hold-off, long enough to back the pipe up into the request side
	localparam int HOLD_OFF = 150;

	typedef struct packed {
		logic [DW-1:0] duty;
		logic          at_target;
		logic          cal_valid;
		logic          en;
		logic          en_n;
	} duty_result_t;

	// predictor of the duty map and ramp, plus the store of expected results
	class duty_scoreboard;
		logic [DW-1:0] cal [NPOINTS];
		logic          drive_en;
		logic [DW-1:0] cur_duty;
		logic [DW-1:0] tgt_duty;
		duty_result_t  expected_duty [$];
		int            failures;

		function new();
			cal[0] = 15'd0;
			cal[1] = 15'd6400;
			cal[2] = 15'd12800;
			cal[3] = 15'd19200;
			cal[4] = 15'd25600;
			drive_en = 1'b0;
			cur_duty = '0;
			tgt_duty = '0;
			failures = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [DW-1:0] data);
			if (idx <= CFG_CAL4)
				cal[int'(idx)] = data;
			else if (idx == CFG_DRIVE_EN)
				drive_en = data[0];
		endfunction

		function logic [DW-1:0] map_gauge(logic signed [15:0] gp);
			longint num;
			longint idx;
			int     seg, k, lo, hi, prod, mag, q;
			num = longint'(gp) * 2 * TABLE_SIZE + FULL_SCALE;
			idx = (num < 0) ? 0 : num / IDX_DEN;
			if (idx > TABLE_SIZE - 1)
				idx = TABLE_SIZE - 1;
			seg = int'(idx / RD);
			if (seg >= NPOINTS - 1)
				return cal[NPOINTS-1];
			k = int'(idx) - seg * RD;
			lo = int'(cal[seg]);
			hi = int'(cal[seg+1]);
			prod = k * (hi - lo);
			mag = (prod < 0) ? -prod : prod;
			q = (2 * mag + RD) / (2 * RD);
			if (prod < 0)
				q = -q;
			return DW'(lo + q);
		endfunction

		function logic cal_ok();
			logic inc;
			inc = cal[1] > cal[0];
			for (int i = 0; i < NPOINTS; i++)
				if (cal[i] > FULL_SCALE)
					return 1'b0;
			for (int i = 0; i < NPOINTS - 1; i++)
				if (inc ? (cal[i+1] <= cal[i]) : (cal[i+1] >= cal[i]))
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_request(mode_t mode, logic signed [15:0] gp);
			duty_result_t exp;
			int           cur_i, tgt_i, delta, gap;
			case (mode)
				MODE_SET: begin
					cur_duty = map_gauge(gp);
					tgt_duty = cur_duty;
				end
				MODE_TARGET: begin
					tgt_duty = map_gauge(gp);
				end
				MODE_TICK: begin
					if (cur_duty != tgt_duty) begin
						cur_i = int'(cur_duty);
						tgt_i = int'(tgt_duty);
						delta = (cur_i > tgt_i) ? -ONE_PERCENT : ONE_PERCENT;
						gap = cur_i + delta - tgt_i;
						if (gap < 0)
							gap = -gap;
						if (gap <= ONE_PERCENT)
							cur_duty = tgt_duty;
						else
							cur_duty = DW'(cur_i + delta);
					end
				end
				default: begin
				end
			endcase
			exp.duty = cur_duty;
			exp.at_target = (cur_duty == tgt_duty);
			exp.cal_valid = cal_ok();
			exp.en = drive_en;
			exp.en_n = ~drive_en;
			expected_duty.push_back(exp);
		endfunction

		function void check_result(duty_result_t got);
			duty_result_t exp;
			if (expected_duty.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: duty %0d at_target %0b cal_valid %0b en %0b/%0b",
						got.duty, got.at_target, got.cal_valid, got.en, got.en_n);
				return;
			end
			exp = expected_duty.pop_front();
			if (got !== exp) begin
				failures++;
				if (failures <= 10)
					$display({"result mismatch: expected duty %0d at_target %0b cal_valid %0b ",
						"en %0b/%0b, got duty %0d at_target %0b cal_valid %0b en %0b/%0b"},
						exp.duty, exp.at_target, exp.cal_valid, exp.en, exp.en_n,
						got.duty, got.at_target, got.cal_valid, got.en, got.en_n);
			end
		endfunction

		function int pending();
			return expected_duty.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	gdm_in_if  req_ch ();
	gdm_out_if res_ch ();
	gdm_cfg_if cfg_ch ();

	gauge_duty_map_with_ramp u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	duty_scoreboard sb = new();

	// idle odds in percent for each side, set per phase
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	// a long receiver hold-off is asked for here and counted down by the receiver
	int hold_req      = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	// result side: random stalls plus the occasional long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				res_ch.ready = 1'b0;
				hold_left--;
			end else begin
				res_ch.ready = ($urandom_range(0, 99) >= snk_stall_pct);
			end
		end
	end

	// every taken result goes straight to the checker
	always @(posedge clk) begin : result_monitor
		duty_result_t got;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready) begin
			got.duty = res_ch.duty;
			got.at_target = res_ch.at_target;
			got.cal_valid = res_ch.cal_valid;
			got.en = res_ch.enable_pin;
			got.en_n = res_ch.enable_pin_n;
			sb.check_result(got);
		end
	end

	// one request; entered and left at a falling edge, valid stays high on exit
	// so back-to-back requests go out with no bubble
	task automatic send_request(mode_t mode, logic signed [15:0] gp);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.mode = mode;
		req_ch.gauge_percent = gp;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(mode, gp);
		@(negedge clk);
	endtask

	task automatic quiet_requests();
		req_ch.valid = 1'b0;
	endtask

	// wait until every expected result is back, then let the pipe settle
	task automatic wait_drain();
		quiet_requests();
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// register write; only called while nothing is in flight
	task automatic write_cfg(cfg_idx_t idx, logic [DW-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic write_cal(int p0, int p1, int p2, int p3, int p4, logic de);
		write_cfg(CFG_CAL0, DW'(p0));
		write_cfg(CFG_CAL1, DW'(p1));
		write_cfg(CFG_CAL2, DW'(p2));
		write_cfg(CFG_CAL3, DW'(p3));
		write_cfg(CFG_CAL4, DW'(p4));
		write_cfg(CFG_DRIVE_EN, DW'(de));
	endtask

	// gauge readings: mostly in -1..101 percent, just around the useful 0..100, some at the
	// field extremes, the rest anywhere in the 16-bit range
	function automatic logic signed [15:0] rand_gauge();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 16'(int'($urandom_range(0, 26112)) - 256);
		if (r < 75)
			case ($urandom_range(0, 4))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				3: return 16'sd25600;
				default: return -16'sd1;
			endcase
		return 16'($urandom());
	endfunction

	task automatic run_directed();
		// mapping extremes and interior points on the straight reset line
		send_request(MODE_SET, 16'sd0);
		send_request(MODE_SET, 16'sd32767);
		send_request(MODE_SET, -16'sd32768);
		send_request(MODE_SET, -16'sd1);
		send_request(MODE_SET, 16'sd128);
		send_request(MODE_SET, 16'sd12800);
		send_request(MODE_SET, 16'sd25472);
		send_request(MODE_SET, 16'sd19000);
		// small ramp up from 0: steps, snap onto the target, then ticks at the target
		send_request(MODE_SET, 16'sd0);
		send_request(MODE_TARGET, 16'sd1000);
		repeat (5) send_request(MODE_TICK, 16'sd0);
		// target at the bottom, one tick down, then an immediate set cancels it
		send_request(MODE_TARGET, -16'sd32768);
		send_request(MODE_TICK, 16'sd32767);
		send_request(MODE_SET, 16'sd6400);
		// unused mode only reports, the reading is ignored
		send_request(MODE_NONE, 16'sd32767);
		wait_drain();

		// first two points equal: calibration reported invalid
		write_cfg(CFG_CAL1, 15'd0);
		send_request(MODE_SET, 16'sd3200);
		wait_drain();

		// strictly falling line is a valid calibration
		write_cal(25600, 19200, 12800, 6400, 0, 1'b0);
		send_request(MODE_SET, 16'sd9000);
		wait_drain();

		// last point out of range, driver enabled
		write_cfg(CFG_CAL4, 15'd32767);
		write_cfg(CFG_DRIVE_EN, 15'd1);
		send_request(MODE_SET, 16'sd25600);
		send_request(MODE_TICK, 16'sd0);
		wait_drain();
	endtask

	// random traffic; mostly target-then-tick ramps so the slew logic gets real
	// work, the rest single sets, lone targets, lone ticks and the unused mode
	task automatic run_random(int n);
		int sent;
		int r;
		int ticks;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				if ($urandom_range(0, 2) == 0) begin
					send_request(MODE_SET, rand_gauge());
					sent++;
				end
				send_request(MODE_TARGET, rand_gauge());
				sent++;
				ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 8);
				repeat (ticks) begin
					send_request(MODE_TICK, 16'($urandom()));
					sent++;
				end
			end else if (r < 85) begin
				send_request(MODE_SET, rand_gauge());
				sent++;
			end else begin
				case ($urandom_range(0, 2))
					0: send_request(MODE_NONE, 16'($urandom()));
					1: send_request(MODE_TICK, 16'($urandom()));
					default: send_request(MODE_TARGET, rand_gauge());
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		int pts [NPOINTS];
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_NONE;
		req_ch.gauge_percent = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_CAL0;
		cfg_ch.data = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed pass at reset calibration, no idling
		run_directed();

		// no idling, straight reset line
		write_cal(0, 6400, 12800, 19200, 25600, 1'b0);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		run_random(80);
		wait_drain();

		// sender idle most cycles, falling line from the field maximum down, with a pause
		// halfway through until every result is back
		write_cal(32767, 24000, 100, 50, 0, 1'b1);
		src_idle_pct = 74;
		snk_stall_pct = 0;
		run_random(40);
		wait_drain();
		run_random(40);
		wait_drain();

		// receiver stalling most cycles, flat top at the field maximum; starts with
		// a long hold-off while requests keep coming so the input side backs up
		write_cal(0, 0, 32767, 32767, 32767, 1'b0);
		src_idle_pct = 0;
		snk_stall_pct = 74;
		hold_req = HOLD_OFF;
		repeat (30) send_request(MODE_SET, rand_gauge());
		run_random(80);
		wait_drain();

		// both sides idling now and then, random calibration, often a valid one
		for (int i = 0; i < NPOINTS; i++)
			pts[i] = $urandom_range(0, 32767);
		if ($urandom_range(0, 1) == 1) begin
			pts[0] = $urandom_range(0, 5000);
			for (int i = 1; i < NPOINTS; i++)
				pts[i] = pts[i-1] + $urandom_range(1, 5000);
		end
		write_cal(pts[0], pts[1], pts[2], pts[3], pts[4], 1'($urandom_range(0, 1)));
		src_idle_pct = 17;
		snk_stall_pct = 17;
		run_random(80);
		wait_drain();

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/gdm_pkg.sv
sv/gdm_if.sv
sv/gdm_cfg_regs.sv
sv/gdm_map.sv
sv/gdm_ramp.sv
sv/gauge_duty_map_with_ramp.sv
dv/gauge_duty_map_with_ramp_test.sv
